// File: sv/lcus_pkg.sv
`timescale 1ns / 1ps

package lcus_pkg;

    localparam int PID_W   = 4;
    localparam int KEY_W   = 32;
    localparam int TS_W    = 16;
    localparam int DEPTH_W = 8;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;
    localparam logic [PID_W-1:0]   IDLE_PID  = 4'd0;
    localparam logic [TS_W-1:0]    TS_RESET  = 16'd2;

    localparam logic [1:0] CMD_RESCHED     = 2'd0;
    localparam logic [1:0] CMD_DEFER_START = 2'd1;
    localparam logic [1:0] CMD_DEFER_STOP  = 2'd2;
    localparam logic [1:0] CMD_MAKE_READY  = 2'd3;

    // Operations the controller asks of the datapath, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_EVAL,
        OP_IDLEW,
        OP_POP_READ,
        OP_POP_WRITE,
        OP_POP_END,
        OP_INS_INIT,
        OP_INS_READ,
        OP_INS_SHIFT,
        OP_INS_PLACE,
        OP_MR_EVAL,
        OP_DEFER_REC,
        OP_DSTART,
        OP_DSTOP,
        OP_DSTOP_ERR,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       depth_zero;
        logic       depth_one;
        logic       pending;
        logic       elig;
        logic       switch_now;
        logic       switch_reg;
        logic       idx_at_cnt;
        logic       idx_zero;
        logic       key_gt;
        logic       mr_ok;
    } dp_stat_t;

endpackage

// File: sv/lcus_datapath.sv
`timescale 1ns / 1ps

module lcus_datapath #(
    parameter int NUM_PROCS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lcus_pkg::dp_op_t           op,
    output lcus_pkg::dp_stat_t         stat,
    input  logic [1:0]                 cmd,
    input  logic [lcus_pkg::KEY_W-1:0] now_ticks,
    input  logic                       current_eligible,
    input  logic [lcus_pkg::PID_W-1:0] ready_pid,
    input  logic                       cfg_valid,
    input  logic [lcus_pkg::TS_W-1:0]  cfg_data,
    output logic                       status,
    output logic                       switched,
    output logic [lcus_pkg::PID_W-1:0] old_pid,
    output logic [lcus_pkg::PID_W-1:0] new_pid,
    output logic                       was_deferred,
    output logic [lcus_pkg::TS_W-1:0]  quantum_reload
);
    import lcus_pkg::*;

    localparam int IDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CNT_W = $clog2(NUM_PROCS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_PROCS);

    // Per-process usage store; valid bits stand in for its all-zero reset.
    logic [KEY_W-1:0] cpu_mem [NUM_PROCS];
    logic [NUM_PROCS-1:0] cpu_vld_reg;
    logic [KEY_W-1:0] cpu_rd_reg;
    logic             vld_rd_reg;

    // Sorted ready list.
    logic [KEY_W-1:0] lkey_mem [NUM_PROCS];
    logic [PID_W-1:0] lpid_mem [NUM_PROCS];
    logic [KEY_W-1:0] lkey_rd_reg;
    logic [PID_W-1:0] lpid_rd_reg;

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [PID_W-1:0]   cur_reg;
    logic [KEY_W-1:0]   stamp_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic               pending_reg;
    logic [TS_W-1:0]    slice_reg;
    logic               sw_reg;

    logic [1:0]       cmd_reg;
    logic [KEY_W-1:0] now_reg;
    logic             elig_reg;
    logic [PID_W-1:0] rpid_reg;
    logic [KEY_W-1:0] elapsed_reg;
    logic [KEY_W-1:0] charged_reg;
    logic [KEY_W-1:0] ins_key_reg;
    logic [PID_W-1:0] ins_pid_reg;

    logic             res_status_reg;
    logic             res_sw_reg;
    logic [PID_W-1:0] res_old_reg;
    logic [PID_W-1:0] res_new_reg;
    logic             res_def_reg;
    logic [TS_W-1:0]  res_qr_reg;

    logic [KEY_W-1:0] used;
    logic [KEY_W-1:0] charged;
    logic             switch_now;
    logic [IDX_W-1:0] cpu_rd_addr;
    logic [IDX_W-1:0] list_rd_addr;
    logic [IDX_W-1:0] list_wr_addr;
    logic             list_we;
    logic [KEY_W-1:0] list_wr_key;
    logic [PID_W-1:0] list_wr_pid;
    logic             cpu_we;
    logic [IDX_W-1:0] cpu_wr_addr;
    logic [KEY_W-1:0] cpu_wr_data;
    logic [CNT_W-1:0] idx_dec;

    assign used       = vld_rd_reg ? cpu_rd_reg : '0;
    assign charged    = used + elapsed_reg;
    assign switch_now = (cnt_reg != '0) && !(elig_reg && (used < lkey_rd_reg));
    assign idx_dec    = idx_reg - CNT_W'(1);

    assign stat.cmd        = cmd_reg;
    assign stat.depth_zero = (depth_reg == '0);
    assign stat.depth_one  = (depth_reg == DEPTH_W'(1));
    assign stat.pending    = pending_reg;
    assign stat.elig       = elig_reg;
    assign stat.switch_now = switch_now;
    assign stat.switch_reg = sw_reg;
    assign stat.idx_at_cnt = (idx_reg == cnt_reg);
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.key_gt     = (lkey_rd_reg > ins_key_reg);
    assign stat.mr_ok      = (32'(rpid_reg) < NUM_PROCS) && (cnt_reg != CNT_FULL);

    always_comb
    begin
        cpu_rd_addr  = (cmd_reg == CMD_MAKE_READY) ? IDX_W'(rpid_reg) : IDX_W'(cur_reg);
        list_rd_addr = '0;
        if (op == OP_POP_READ)
            list_rd_addr = idx_reg[IDX_W-1:0];
        else if (op == OP_INS_READ)
            list_rd_addr = idx_dec[IDX_W-1:0];

        list_we      = 1'b0;
        list_wr_addr = idx_reg[IDX_W-1:0];
        list_wr_key  = lkey_rd_reg;
        list_wr_pid  = lpid_rd_reg;
        case (op)
            OP_POP_WRITE:
            begin
                list_we      = 1'b1;
                list_wr_addr = idx_dec[IDX_W-1:0];
            end
            OP_INS_SHIFT:
                list_we = 1'b1;
            OP_INS_PLACE:
            begin
                list_we     = 1'b1;
                list_wr_key = ins_key_reg;
                list_wr_pid = ins_pid_reg;
            end
            default:
                list_we = 1'b0;
        endcase

        cpu_we      = 1'b0;
        cpu_wr_addr = IDX_W'(cur_reg);
        cpu_wr_data = charged;
        if (op == OP_EVAL)
            cpu_we = 1'b1;
        else if (op == OP_IDLEW)
        begin
            cpu_we      = 1'b1;
            cpu_wr_addr = IDX_W'(IDLE_PID);
            cpu_wr_data = charged_reg + KEY_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cpu_we)
            cpu_mem[cpu_wr_addr] <= cpu_wr_data;
        if (op == OP_READ)
            cpu_rd_reg <= cpu_mem[cpu_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            lkey_mem[list_wr_addr] <= list_wr_key;
            lpid_mem[list_wr_addr] <= list_wr_pid;
        end
        if (op == OP_READ || op == OP_POP_READ || op == OP_INS_READ)
        begin
            lkey_rd_reg <= lkey_mem[list_rd_addr];
            lpid_rd_reg <= lpid_mem[list_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_vld_reg <= '0;
            vld_rd_reg  <= 1'b0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            cur_reg     <= IDLE_PID;
            stamp_reg   <= '0;
            depth_reg   <= '0;
            pending_reg <= 1'b0;
            slice_reg   <= TS_RESET;
            sw_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                slice_reg <= cfg_data;
            if (cpu_we)
                cpu_vld_reg[cpu_wr_addr] <= 1'b1;
            case (op)
                OP_READ:
                    vld_rd_reg <= cpu_vld_reg[cpu_rd_addr];
                OP_EVAL:
                begin
                    stamp_reg <= now_reg;
                    sw_reg    <= switch_now;
                    if (switch_now)
                        cur_reg <= lpid_rd_reg;
                end
                OP_IDLEW:
                    idx_reg <= CNT_W'(1);
                OP_POP_WRITE:
                    idx_reg <= idx_reg + CNT_W'(1);
                OP_POP_END:
                    cnt_reg <= cnt_reg - CNT_W'(1);
                OP_INS_INIT:
                    idx_reg <= cnt_reg;
                OP_INS_SHIFT:
                    idx_reg <= idx_dec;
                OP_INS_PLACE:
                    cnt_reg <= cnt_reg + CNT_W'(1);
                OP_DEFER_REC:
                    pending_reg <= 1'b1;
                OP_DSTART:
                begin
                    if (depth_reg == '0)
                        pending_reg <= 1'b0;
                    if (depth_reg != DEPTH_MAX)
                        depth_reg <= depth_reg + DEPTH_W'(1);
                end
                OP_DSTOP:
                    depth_reg <= depth_reg - DEPTH_W'(1);
                default:
                    sw_reg <= sw_reg;
            endcase
        end
    end

    // Item capture, working values and the result being built.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_reg        <= cmd;
                now_reg        <= now_ticks;
                elig_reg       <= current_eligible;
                rpid_reg       <= ready_pid;
                res_status_reg <= 1'b0;
                res_sw_reg     <= 1'b0;
                res_old_reg    <= cur_reg;
                res_new_reg    <= cur_reg;
                res_def_reg    <= 1'b0;
                res_qr_reg     <= '0;
            end
            OP_READ:
                elapsed_reg <= now_reg - stamp_reg;
            OP_EVAL:
            begin
                charged_reg <= charged;
                ins_key_reg <= charged;
                ins_pid_reg <= cur_reg;
                if (switch_now)
                begin
                    res_sw_reg  <= 1'b1;
                    res_new_reg <= lpid_rd_reg;
                    res_qr_reg  <= slice_reg;
                end
                if (cnt_reg == '0 && !elig_reg && cmd_reg == CMD_RESCHED)
                    res_status_reg <= 1'b1;
            end
            OP_MR_EVAL:
            begin
                ins_key_reg <= used;
                ins_pid_reg <= rpid_reg;
                if (!stat.mr_ok)
                    res_status_reg <= 1'b1;
            end
            OP_DEFER_REC:
                res_def_reg <= 1'b1;
            OP_DSTOP_ERR:
                res_status_reg <= 1'b1;
            OP_PUBLISH:
            begin
                status         <= res_status_reg;
                switched       <= res_sw_reg;
                old_pid        <= res_old_reg;
                new_pid        <= res_new_reg;
                was_deferred   <= res_def_reg;
                quantum_reload <= res_qr_reg;
            end
            default:
                cmd_reg <= cmd_reg;
        endcase
    end

endmodule

// File: sv/lcus_controller.sv
`timescale 1ns / 1ps

module lcus_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  lcus_pkg::dp_stat_t stat,
    output lcus_pkg::dp_op_t   op
);
    import lcus_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RS_READ,
        ST_RS_EVAL,
        ST_RS_IDLEW,
        ST_POP_CHK,
        ST_POP_WR,
        ST_INS_INIT,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_MR_EVAL,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NONE;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            ST_DISPATCH:
                case (stat.cmd)
                    CMD_RESCHED:
                        if (!stat.depth_zero)
                        begin
                            op         = OP_DEFER_REC;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            op         = OP_READ;
                            state_next = ST_RS_EVAL;
                        end
                    CMD_DEFER_START:
                    begin
                        op         = OP_DSTART;
                        state_next = ST_FINISH;
                    end
                    CMD_DEFER_STOP:
                        if (stat.depth_zero)
                        begin
                            op         = OP_DSTOP_ERR;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            op         = OP_DSTOP;
                            state_next = (stat.depth_one && stat.pending) ? ST_RS_READ
                                                                           : ST_FINISH;
                        end
                    default:
                    begin
                        op         = OP_READ;
                        state_next = ST_MR_EVAL;
                    end
                endcase
            ST_RS_READ:
            begin
                op         = OP_READ;
                state_next = ST_RS_EVAL;
            end
            ST_RS_EVAL:
            begin
                op         = OP_EVAL;
                state_next = ST_RS_IDLEW;
            end
            ST_RS_IDLEW:
            begin
                op         = OP_IDLEW;
                state_next = stat.switch_reg ? ST_POP_CHK : ST_FINISH;
            end
            ST_POP_CHK:
                if (stat.idx_at_cnt)
                begin
                    op         = OP_POP_END;
                    state_next = stat.elig ? ST_INS_INIT : ST_FINISH;
                end
                else
                begin
                    op         = OP_POP_READ;
                    state_next = ST_POP_WR;
                end
            ST_POP_WR:
            begin
                op         = OP_POP_WRITE;
                state_next = ST_POP_CHK;
            end
            ST_INS_INIT:
            begin
                op         = OP_INS_INIT;
                state_next = ST_INS_CHK;
            end
            ST_INS_CHK:
                if (stat.idx_zero)
                begin
                    op         = OP_INS_PLACE;
                    state_next = ST_FINISH;
                end
                else
                begin
                    op         = OP_INS_READ;
                    state_next = ST_INS_CMP;
                end
            ST_INS_CMP:
                if (stat.key_gt)
                begin
                    op         = OP_INS_SHIFT;
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    op         = OP_INS_PLACE;
                    state_next = ST_FINISH;
                end
            ST_MR_EVAL:
            begin
                op         = OP_MR_EVAL;
                state_next = stat.mr_ok ? ST_INS_INIT : ST_FINISH;
            end
            ST_FINISH:
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/least_cpu_used_scheduler_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Contents
// in        input      in_valid / in_ready    cmd, now_ticks, current_eligible, ready_pid
// out       output     out_valid / out_ready  status, switched, old_pid, new_pid,
//                                             was_deferred, quantum_reload
// cfg       input      cfg_valid / cfg_ready  cfg_data (time slice)
//
// One item is worked at a time. A switch shifts each remaining ready-list entry
// towards the head, and reinsertion steps back over the entries whose key is
// larger. The single-port ready-list memory is walked one entry per read and
// write pair.
// Reset is asynchronous and active low; no clearing pass is needed, since
// per-process usage is covered by valid bits.
// The finished result sits in an output register, so a new item is taken while
// it waits; the following result stalls only when the register is still full.

module least_cpu_used_scheduler_core #(
    parameter int NUM_PROCS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 cmd,
    input  logic [lcus_pkg::KEY_W-1:0] now_ticks,
    input  logic                       current_eligible,
    input  logic [lcus_pkg::PID_W-1:0] ready_pid,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       status,
    output logic                       switched,
    output logic [lcus_pkg::PID_W-1:0] old_pid,
    output logic [lcus_pkg::PID_W-1:0] new_pid,
    output logic                       was_deferred,
    output logic [lcus_pkg::TS_W-1:0]  quantum_reload,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lcus_pkg::TS_W-1:0]  cfg_data
);
    import lcus_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    // The time slice register can take a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences each command; the datapath holds the scheduler state.
    lcus_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .op        (op)
    );

    lcus_datapath #(
        .NUM_PROCS (NUM_PROCS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .stat             (stat),
        .cmd              (cmd),
        .now_ticks        (now_ticks),
        .current_eligible (current_eligible),
        .ready_pid        (ready_pid),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .status           (status),
        .switched         (switched),
        .old_pid          (old_pid),
        .new_pid          (new_pid),
        .was_deferred     (was_deferred),
        .quantum_reload   (quantum_reload)
    );

endmodule

// File: sv/lcus_checker.sv
`timescale 1ns / 1ps

module lcus_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       switched,
    input logic [lcus_pkg::PID_W-1:0] old_pid,
    input logic [lcus_pkg::PID_W-1:0] new_pid,
    input logic                       was_deferred,
    input logic [lcus_pkg::TS_W-1:0]  quantum_reload
);

    // A held result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_pid) && $stable(switched))
        else $error("result changed while stalled");

    // Only one item is worked on at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    a_no_quantum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !switched |-> quantum_reload == '0)
        else $error("quantum reported without a switch");

    a_deferred: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_deferred |-> !switched && new_pid == old_pid)
        else $error("deferred reschedule changed the current process");

endmodule

bind least_cpu_used_scheduler_core lcus_checker u_lcus_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .switched       (switched),
    .old_pid        (old_pid),
    .new_pid        (new_pid),
    .was_deferred   (was_deferred),
    .quantum_reload (quantum_reload)
);
